// ===== rtl/fsnc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsnc_pkg
// Shared constants and types of the FAT 8.3 short-name converter.
// ----------------------------------------------------------------------------
package fsnc_pkg;

	// Name geometry
	localparam int NAME_BYTES = 11;
	localparam int EXT_START  = 8;
	localparam int EXT_LEN    = NAME_BYTES - EXT_START;
	localparam int POS_W      = $clog2(NAME_BYTES + 1);

	// Field widths
	localparam int CH_W    = 8;
	localparam int BODY_W  = CH_W * EXT_START;
	localparam int EXT_W   = CH_W * EXT_LEN;
	localparam int CFG_W   = BODY_W;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BODY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_EXT  = 1'd1;

	// Special bytes
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CH_W-1:0] CASE_BIT = 8'h20;

	// Register reset values
	localparam logic [BODY_W-1:0] TARGET_BODY_RST = {EXT_START{CH_SPACE}};
	localparam logic [EXT_W-1:0]  TARGET_EXT_RST  = {EXT_LEN{CH_SPACE}};

	// Converted name as seen after the current byte
	typedef struct packed {
		logic [BODY_W-1:0] name_body;
		logic [EXT_W-1:0]  name_ext;
		logic              body_lower;
		logic              ext_lower;
		logic              overflowed;
	} fsnc_result_t;

endpackage

// ===== rtl/fsnc_in_if.sv =====
// ----------------------------------------------------------------------------
// fsnc_in_if
// Path byte channel: one byte per item plus an end-of-path mark.
// ----------------------------------------------------------------------------
interface fsnc_in_if;
	logic                     valid;
	logic                     ready;
	logic [fsnc_pkg::CH_W-1:0] ch;
	logic                     last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== rtl/fsnc_out_if.sv =====
// ----------------------------------------------------------------------------
// fsnc_out_if
// Result channel: converted 8.3 name, case flags, match and overflow.
// ----------------------------------------------------------------------------
interface fsnc_out_if;
	logic                        valid;
	logic                        ready;
	logic [fsnc_pkg::BODY_W-1:0] name_body;
	logic [fsnc_pkg::EXT_W-1:0]  name_ext;
	logic                        body_lower;
	logic                        ext_lower;
	logic                        is_match;
	logic                        overflowed;

	modport source (output valid, output name_body, output name_ext, output body_lower,
		output ext_lower, output is_match, output overflowed, input ready);
	modport sink   (input valid, input name_body, input name_ext, input body_lower,
		input ext_lower, input is_match, input overflowed, output ready);
endinterface

// ===== rtl/fat_short_name_converter_core.sv =====
// ----------------------------------------------------------------------------
// fat_short_name_converter_core
// Converts the first component of a byte-serial path into a FAT 8.3 name
// and compares it against a configured directory name.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  path_in    in   valid / ready    ch[7:0], last
//  name_out   out  valid / ready    name_body[63:0], name_ext[23:0],
//                                   body_lower, ext_lower, is_match, overflowed
//  cfg        in   cfg_we           cfg_index[0:0], cfg_wdata[63:0]
//
// One byte is taken per cycle; the result of a path is registered at the edge
// that accepts its last byte and is offered from the following cycle. The
// single result register sets the rate: path_in stays ready while it is
// empty or being drained in the same cycle.
// Reset returns the parser to an empty name and the target to all spaces.
// ----------------------------------------------------------------------------
module fat_short_name_converter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	fsnc_in_if.sink                        path_in,
	fsnc_out_if.source                     name_out,
	input  logic                           cfg_we,
	input  logic [fsnc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsnc_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [fsnc_pkg::BODY_W-1:0] target_body_q;
	logic [fsnc_pkg::EXT_W-1:0]  target_ext_q;
	logic                        out_valid_q;
	fsnc_pkg::fsnc_result_t      res_q;
	logic                        match_q;
	fsnc_pkg::fsnc_result_t      result;
	logic                        take;

	// Accept while the result register is free or draining
	assign path_in.ready = !out_valid_q || name_out.ready;
	assign take          = path_in.valid && path_in.ready;

	fsnc_name_builder u_builder (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ch     (path_in.ch),
		.last   (path_in.last),
		.result (result)
	);

	// Hold the configured name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_body_q <= fsnc_pkg::TARGET_BODY_RST;
			target_ext_q  <= fsnc_pkg::TARGET_EXT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fsnc_pkg::CFG_TARGET_BODY: target_body_q <= cfg_wdata;
				fsnc_pkg::CFG_TARGET_EXT:  target_ext_q  <= cfg_wdata[fsnc_pkg::EXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && path_in.last) begin
			out_valid_q <= 1'b1;
		end else if (name_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result on the last item of a path
	always_ff @(posedge clk) begin
		if (take && path_in.last) begin
			res_q   <= result;
			match_q <= (result.name_body == target_body_q) &&
				(result.name_ext == target_ext_q);
		end
	end

	assign name_out.valid      = out_valid_q;
	assign name_out.name_body  = res_q.name_body;
	assign name_out.name_ext   = res_q.name_ext;
	assign name_out.body_lower = res_q.body_lower;
	assign name_out.ext_lower  = res_q.ext_lower;
	assign name_out.is_match   = match_q;
	assign name_out.overflowed = res_q.overflowed;

endmodule

// ===== rtl/fsnc_name_builder.sv =====
// ----------------------------------------------------------------------------
// fsnc_name_builder
// Per-path state: name buffer, write position, parse phase and case flags.
// Presents the name as it stands after the byte on its input.
// ----------------------------------------------------------------------------
module fsnc_name_builder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic [fsnc_pkg::CH_W-1:0] ch,
	input  logic                      last,
	output fsnc_pkg::fsnc_result_t    result
);

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_NAME,
		PH_DONE
	} phase_t;

	logic [fsnc_pkg::CH_W-1:0]  store_q [fsnc_pkg::NAME_BYTES];
	logic [fsnc_pkg::POS_W-1:0] pos_q;
	phase_t                     phase_q;
	logic                       seen_q, dot_after_q, chars_after_q;
	logic                       low_before_q, low_after_q, ovf_q;

	logic [fsnc_pkg::CH_W-1:0]  store_d [fsnc_pkg::NAME_BYTES];
	logic [fsnc_pkg::POS_W-1:0] pos_d;
	phase_t                     phase_d;
	logic                       seen_d, dot_after_d, chars_after_d;
	logic                       low_before_d, low_after_d, ovf_d;
	logic                       do_char, is_low, has_ext;
	logic [fsnc_pkg::CH_W-1:0]  up_ch;

	// Decide whether this byte belongs to the name
	always_comb begin
		phase_d = phase_q;
		do_char = 1'b0;
		case (phase_q)
			PH_SKIP: begin
				if (ch == fsnc_pkg::CH_NUL) begin
					phase_d = PH_DONE;
				end else if (ch != fsnc_pkg::CH_SLASH) begin
					phase_d = PH_NAME;
					do_char = 1'b1;
				end
			end
			PH_NAME: begin
				if (ch == fsnc_pkg::CH_NUL || ch == fsnc_pkg::CH_SLASH) begin
					phase_d = PH_DONE;
				end else begin
					do_char = 1'b1;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// Store one name byte, upper-cased; a dot jumps to the extension
	always_comb begin
		is_low = (ch >= fsnc_pkg::CH_LO_A) && (ch <= fsnc_pkg::CH_LO_Z);
		up_ch  = is_low ? (ch & ~fsnc_pkg::CASE_BIT) : ch;
		store_d       = store_q;
		pos_d         = pos_q;
		seen_d        = seen_q;
		dot_after_d   = dot_after_q;
		chars_after_d = chars_after_q;
		low_before_d  = low_before_q;
		low_after_d   = low_after_q;
		ovf_d         = ovf_q;
		if (do_char) begin
			seen_d = 1'b1;
			if (ch == fsnc_pkg::CH_DOT) begin
				dot_after_d   = seen_q;
				chars_after_d = 1'b0;
				low_before_d  = low_before_q | low_after_q;
				low_after_d   = 1'b0;
				pos_d         = fsnc_pkg::POS_W'(fsnc_pkg::EXT_START);
			end else begin
				low_after_d   = low_after_q | is_low;
				chars_after_d = 1'b1;
				if (pos_q < fsnc_pkg::POS_W'(fsnc_pkg::NAME_BYTES)) begin
					for (int i = 0; i < fsnc_pkg::NAME_BYTES; i++) begin
						if (pos_q == fsnc_pkg::POS_W'(i)) begin
							store_d[i] = up_ch;
						end
					end
					pos_d = pos_q + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	// Pack the name and resolve the case flags by the last dot
	always_comb begin
		for (int i = 0; i < fsnc_pkg::EXT_START; i++) begin
			result.name_body[i*fsnc_pkg::CH_W +: fsnc_pkg::CH_W] = store_d[i];
		end
		for (int i = 0; i < fsnc_pkg::EXT_LEN; i++) begin
			result.name_ext[i*fsnc_pkg::CH_W +: fsnc_pkg::CH_W] =
				store_d[fsnc_pkg::EXT_START + i];
		end
		has_ext           = dot_after_d & chars_after_d;
		result.body_lower = has_ext ? low_before_d : (low_before_d | low_after_d);
		result.ext_lower  = has_ext & low_after_d;
		result.overflowed = ovf_d;
	end

	// Advance on each item; drop back to the empty name after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fsnc_pkg::NAME_BYTES; i++) begin
				store_q[i] <= fsnc_pkg::CH_SPACE;
			end
			pos_q         <= '0;
			phase_q       <= PH_SKIP;
			seen_q        <= 1'b0;
			dot_after_q   <= 1'b0;
			chars_after_q <= 1'b0;
			low_before_q  <= 1'b0;
			low_after_q   <= 1'b0;
			ovf_q         <= 1'b0;
		end else if (take) begin
			if (last) begin
				for (int i = 0; i < fsnc_pkg::NAME_BYTES; i++) begin
					store_q[i] <= fsnc_pkg::CH_SPACE;
				end
				pos_q         <= '0;
				phase_q       <= PH_SKIP;
				seen_q        <= 1'b0;
				dot_after_q   <= 1'b0;
				chars_after_q <= 1'b0;
				low_before_q  <= 1'b0;
				low_after_q   <= 1'b0;
				ovf_q         <= 1'b0;
			end else begin
				store_q       <= store_d;
				pos_q         <= pos_d;
				phase_q       <= phase_d;
				seen_q        <= seen_d;
				dot_after_q   <= dot_after_d;
				chars_after_q <= chars_after_d;
				low_before_q  <= low_before_d;
				low_after_q   <= low_after_d;
				ovf_q         <= ovf_d;
			end
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT 8.3 short-name converter: a directed table
// of paths, then random paths under several target names and idle patterns,
// every result without a typed expectation checked against a bit-accurate name predictor.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [fsnc_pkg::BODY_W-1:0] name_body;
		logic [fsnc_pkg::EXT_W-1:0]  name_ext;
		logic                        body_lower;
		logic                        ext_lower;
		logic                        is_match;
		logic                        overflowed;
	} name_res_t;

	typedef struct packed {
		logic [fsnc_pkg::CH_W-1:0] ch;
		logic                      last;
		logic                      typed;
		name_res_t                 res;
	} dir_row_t;

	typedef enum logic [1:0] {SCAN_SKIP, SCAN_NAME, SCAN_DONE} scan_state_t;

	localparam name_res_t EMPTY_HIT = '{name_body: fsnc_pkg::TARGET_BODY_RST,
		name_ext: fsnc_pkg::TARGET_EXT_RST, body_lower: 1'b0, ext_lower: 1'b0,
		is_match: 1'b1, overflowed: 1'b0};
	localparam name_res_t NO_RES = '0;
	localparam int DIR_ROWS = 24;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 225;

	// Directed paths; typed expectations only where the answer is obvious
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// empty paths: NUL alone, lone slash, NUL then an ignored byte
		'{fsnc_pkg::CH_NUL,   1'b1, 1'b1, EMPTY_HIT},
		'{fsnc_pkg::CH_SLASH, 1'b1, 1'b1, EMPTY_HIT},
		'{fsnc_pkg::CH_NUL,   1'b0, 1'b0, NO_RES},
		'{8'hFF,              1'b1, 1'b1, EMPTY_HIT},
		// "//aB.c": leading slashes, mixed case, extension
		'{fsnc_pkg::CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{fsnc_pkg::CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{8'h61,              1'b0, 1'b0, NO_RES},
		'{8'h42,              1'b0, 1'b0, NO_RES},
		'{fsnc_pkg::CH_DOT,   1'b0, 1'b0, NO_RES},
		'{8'h63,              1'b1, 1'b0, NO_RES},
		// "a.bcde": extension too long, the e is dropped
		'{8'h61,              1'b0, 1'b0, NO_RES},
		'{fsnc_pkg::CH_DOT,   1'b0, 1'b0, NO_RES},
		'{8'h62,              1'b0, 1'b0, NO_RES},
		'{8'h63,              1'b0, 1'b0, NO_RES},
		'{8'h64,              1'b0, 1'b0, NO_RES},
		'{8'h65,              1'b1, 1'b0, NO_RES},
		// high bytes stored as is, NUL ends the component, tail ignored
		'{8'hFF,              1'b0, 1'b0, NO_RES},
		'{8'h80,              1'b0, 1'b0, NO_RES},
		'{fsnc_pkg::CH_NUL,   1'b0, 1'b0, NO_RES},
		'{8'h71,              1'b1, 1'b0, NO_RES},
		// dot as the first character
		'{fsnc_pkg::CH_DOT,   1'b0, 1'b0, NO_RES},
		'{8'h61,              1'b1, 1'b0, NO_RES},
		// trailing dot with nothing after it
		'{8'h41,              1'b0, 1'b0, NO_RES},
		'{fsnc_pkg::CH_DOT,   1'b1, 1'b0, NO_RES}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [fsnc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fsnc_pkg::CFG_W-1:0]     cfg_wdata;

	fsnc_in_if  path_in();
	fsnc_out_if name_out();

	fat_short_name_converter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.path_in   (path_in),
		.name_out  (name_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state and its copy of the target name
	logic [fsnc_pkg::CH_W-1:0]   sn_store [fsnc_pkg::NAME_BYTES];
	logic [fsnc_pkg::POS_W-1:0]  sn_pos;
	scan_state_t                 scan_st;
	logic                        sn_seen;
	logic                        sn_dot_mid;
	logic                        sn_ext_chars;
	logic                        sn_low_body;
	logic                        sn_low_ext;
	logic                        sn_ovf;
	logic [fsnc_pkg::BODY_W-1:0] tgt_body;
	logic [fsnc_pkg::EXT_W-1:0]  tgt_ext;

	// Target word of the current phase and the path under construction
	logic [fsnc_pkg::CH_W-1:0]   word_chars [fsnc_pkg::NAME_BYTES];
	int                          word_blen;
	int                          word_elen;
	logic [fsnc_pkg::BODY_W-1:0] word_body;
	logic [fsnc_pkg::EXT_W-1:0]  word_ext;
	logic                        use_word;
	logic [fsnc_pkg::CH_W-1:0]   path_bytes [$];

	name_res_t pending_names [$];
	name_res_t want;
	int        mism_cnt = 0;
	int        src_idle_pct = 0;
	int        snk_stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(5_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		mism_cnt++;
	endtask

	task automatic check_field(input string fld, input logic [63:0] got,
		input logic [63:0] exp_val);
		if (got !== exp_val) begin
			report_error($sformatf("%s got %h expected %h", fld, got, exp_val));
		end
	endtask

	function automatic void clear_name();
		foreach (sn_store[i]) sn_store[i] = fsnc_pkg::CH_SPACE;
		sn_pos       = '0;
		scan_st      = SCAN_SKIP;
		sn_seen      = 1'b0;
		sn_dot_mid   = 1'b0;
		sn_ext_chars = 1'b0;
		sn_low_body  = 1'b0;
		sn_low_ext   = 1'b0;
		sn_ovf       = 1'b0;
	endfunction

	// Store one component character, upper-cased, or jump to the extension
	function automatic void take_char(input logic [fsnc_pkg::CH_W-1:0] c);
		logic [fsnc_pkg::CH_W-1:0] b;
		b = c;
		if (c == fsnc_pkg::CH_DOT) begin
			sn_dot_mid   = sn_seen;
			sn_ext_chars = 1'b0;
			sn_low_body  = sn_low_body | sn_low_ext;
			sn_low_ext   = 1'b0;
			sn_pos       = fsnc_pkg::POS_W'(fsnc_pkg::EXT_START);
		end else begin
			if (c >= fsnc_pkg::CH_LO_A && c <= fsnc_pkg::CH_LO_Z) begin
				sn_low_ext = 1'b1;
				b = c & ~fsnc_pkg::CASE_BIT;
			end
			sn_ext_chars = 1'b1;
			if (sn_pos < fsnc_pkg::POS_W'(fsnc_pkg::NAME_BYTES)) begin
				sn_store[sn_pos] = b;
				sn_pos = sn_pos + 1'b1;
			end else begin
				sn_ovf = 1'b1;
			end
		end
		sn_seen = 1'b1;
	endfunction

	// Advance the converter by one byte; return 1 with the name on a last byte
	function automatic logic convert_byte(input logic [fsnc_pkg::CH_W-1:0] c,
		input logic l, output name_res_t r);
		logic has_ext;
		r = '0;
		case (scan_st)
			SCAN_SKIP: begin
				if (c == fsnc_pkg::CH_NUL) scan_st = SCAN_DONE;
				else if (c != fsnc_pkg::CH_SLASH) begin
					scan_st = SCAN_NAME;
					take_char(c);
				end
			end
			SCAN_NAME: begin
				if (c == fsnc_pkg::CH_NUL || c == fsnc_pkg::CH_SLASH) scan_st = SCAN_DONE;
				else take_char(c);
			end
			default: ;
		endcase
		if (!l) return 1'b0;
		for (int i = 0; i < fsnc_pkg::EXT_START; i++) r.name_body[8*i +: 8] = sn_store[i];
		for (int i = 0; i < fsnc_pkg::EXT_LEN; i++) begin
			r.name_ext[8*i +: 8] = sn_store[fsnc_pkg::EXT_START + i];
		end
		has_ext      = sn_dot_mid & sn_ext_chars;
		r.body_lower = has_ext ? sn_low_body : (sn_low_body | sn_low_ext);
		r.ext_lower  = has_ext & sn_low_ext;
		r.is_match   = (r.name_body == tgt_body) && (r.name_ext == tgt_ext);
		r.overflowed = sn_ovf;
		clear_name();
		return 1'b1;
	endfunction

	// Random name character: never NUL, slash or dot
	function automatic logic [fsnc_pkg::CH_W-1:0] pick_char();
		logic [fsnc_pkg::CH_W-1:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = fsnc_pkg::CH_LO_A + 8'($urandom_range(0, 25));
			4, 5:       c = 8'h41 + 8'($urandom_range(0, 25));
			6:          c = 8'h30 + 8'($urandom_range(0, 9));
			7: begin
				c = 8'($urandom_range(1, 127));
				if (c == fsnc_pkg::CH_DOT || c == fsnc_pkg::CH_SLASH) c = 8'h60;
			end
			default:    c = 8'h80 + 8'($urandom_range(0, 127));
		endcase
		return c;
	endfunction

	function automatic logic [fsnc_pkg::CH_W-1:0] maybe_lower(
		input logic [fsnc_pkg::CH_W-1:0] c);
		if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
			return c | fsnc_pkg::CASE_BIT;
		end
		return c;
	endfunction

	function automatic void pick_word();
		word_blen = $urandom_range(1, fsnc_pkg::EXT_START);
		word_elen = $urandom_range(0, fsnc_pkg::EXT_LEN);
		word_body = fsnc_pkg::TARGET_BODY_RST;
		word_ext  = fsnc_pkg::TARGET_EXT_RST;
		foreach (word_chars[i]) begin
			word_chars[i] = ($urandom_range(0, 3) == 0) ? 8'h30 + 8'($urandom_range(0, 9))
				: 8'h41 + 8'($urandom_range(0, 25));
		end
		for (int i = 0; i < word_blen; i++) word_body[8*i +: 8] = word_chars[i];
		for (int i = 0; i < word_elen; i++) begin
			word_ext[8*i +: 8] = word_chars[fsnc_pkg::EXT_START + i];
		end
	endfunction

	// Assemble one random path; mostly well formed, some overlong, some noise
	function automatic void build_path();
		int kind;
		int n;
		path_bytes.delete();
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			n = $urandom_range(0, (kind < 70) ? 2 : 1);
			repeat (n) path_bytes.push_back(fsnc_pkg::CH_SLASH);
		end
		if (kind < 30 && use_word) begin
			for (int i = 0; i < word_blen; i++) path_bytes.push_back(maybe_lower(word_chars[i]));
			if (word_elen > 0) path_bytes.push_back(fsnc_pkg::CH_DOT);
			for (int i = 0; i < word_elen; i++) begin
				path_bytes.push_back(maybe_lower(word_chars[fsnc_pkg::EXT_START + i]));
			end
		end else if (kind < 70) begin
			repeat ($urandom_range(0, fsnc_pkg::EXT_START)) path_bytes.push_back(pick_char());
			if ($urandom_range(0, 1) == 1) begin
				path_bytes.push_back(fsnc_pkg::CH_DOT);
				repeat ($urandom_range(0, fsnc_pkg::EXT_LEN + 1)) begin
					path_bytes.push_back(pick_char());
				end
			end
		end else if (kind < 85) begin
			repeat ($urandom_range(9, 14)) begin
				path_bytes.push_back(($urandom_range(0, 9) == 0) ? fsnc_pkg::CH_DOT
					: pick_char());
			end
		end else begin
			repeat ($urandom_range(1, 6)) path_bytes.push_back(8'($urandom_range(0, 255)));
		end
		// optional terminator with trailing junk that must be ignored
		if (kind < 85 && $urandom_range(0, 9) < 3) begin
			path_bytes.push_back(($urandom_range(0, 1) == 1) ? fsnc_pkg::CH_SLASH
				: fsnc_pkg::CH_NUL);
			repeat ($urandom_range(0, 3)) path_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (path_bytes.size() == 0) begin
			path_bytes.push_back(($urandom_range(0, 1) == 1) ? fsnc_pkg::CH_SLASH
				: fsnc_pkg::CH_NUL);
		end
	endfunction

	// Offer one item, hold it until taken, then record what it should produce
	task automatic send_byte(input logic [fsnc_pkg::CH_W-1:0] c, input logic l,
		input logic typed, input name_res_t typed_res);
		name_res_t calc;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			path_in.valid <= 1'b0;
			@(posedge clk);
		end
		path_in.valid <= 1'b1;
		path_in.ch    <= c;
		path_in.last  <= l;
		@(posedge clk);
		while (!path_in.ready) @(posedge clk);
		if (convert_byte(c, l, calc)) pending_names.push_back(typed ? typed_res : calc);
	endtask

	// Drop valid, let every expected name arrive, then let the block settle
	task automatic end_burst();
		path_in.valid <= 1'b0;
		while (pending_names.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write_target(input logic [fsnc_pkg::BODY_W-1:0] body,
		input logic [fsnc_pkg::EXT_W-1:0] ext);
		logic [fsnc_pkg::CFG_W-1:0] junk;
		junk = {$urandom, $urandom};
		cfg_we    <= 1'b1;
		cfg_index <= fsnc_pkg::CFG_TARGET_BODY;
		cfg_wdata <= body;
		@(posedge clk);
		cfg_index <= fsnc_pkg::CFG_TARGET_EXT;
		cfg_wdata <= {junk[fsnc_pkg::CFG_W-1:fsnc_pkg::EXT_W], ext};
		@(posedge clk);
		cfg_we   <= 1'b0;
		tgt_body = body;
		tgt_ext  = ext;
	endtask

	// Check each name taken and draw the next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (name_out.valid && name_out.ready) begin
				if (pending_names.size() == 0) begin
					report_error("name result with nothing pending");
				end else begin
					want = pending_names.pop_front();
					check_field("name_body", 64'(name_out.name_body), 64'(want.name_body));
					check_field("name_ext", 64'(name_out.name_ext), 64'(want.name_ext));
					check_field("body_lower", 64'(name_out.body_lower),
						64'(want.body_lower));
					check_field("ext_lower", 64'(name_out.ext_lower), 64'(want.ext_lower));
					check_field("is_match", 64'(name_out.is_match), 64'(want.is_match));
					check_field("overflowed", 64'(name_out.overflowed),
						64'(want.overflowed));
				end
			end
			name_out.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	initial begin
		int n_sent;
		arst_n         = 1'b0;
		path_in.valid  = 1'b0;
		path_in.ch     = '0;
		path_in.last   = 1'b0;
		name_out.ready = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = fsnc_pkg::CFG_TARGET_BODY;
		cfg_wdata      = '0;
		use_word       = 1'b0;
		tgt_body       = fsnc_pkg::TARGET_BODY_RST;
		tgt_ext        = fsnc_pkg::TARGET_EXT_RST;
		clear_name();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table against the reset target
		for (int r = 0; r < DIR_ROWS; r++) begin
			send_byte(DIR_TABLE[r].ch, DIR_TABLE[r].last, DIR_TABLE[r].typed,
				DIR_TABLE[r].res);
		end
		end_burst();

		// Random phases: new target and idle pattern each time
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
				default: begin src_idle_pct = 18; snk_stall_pct = 18; end
			endcase
			case (p)
				0: begin
					use_word = 1'b0;
					cfg_write_target('0, '0);
				end
				1: begin
					use_word = 1'b0;
					cfg_write_target('1, '1);
				end
				default: begin
					pick_word();
					use_word = 1'b1;
					cfg_write_target(word_body, word_ext);
				end
			endcase
			n_sent = 0;
			while (n_sent < PHASE_ITEMS) begin
				build_path();
				foreach (path_bytes[i]) begin
					send_byte(path_bytes[i], i == path_bytes.size() - 1, 1'b0, NO_RES);
				end
				n_sent += path_bytes.size();
			end
			end_burst();
		end

		if (mism_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fsnc_pkg.sv
rtl/fsnc_in_if.sv
rtl/fsnc_out_if.sv
rtl/fsnc_name_builder.sv
rtl/fat_short_name_converter_core.sv
test/tb_top.sv
